// ===== src/gpc_pkg.sv =====
// gpc_pkg: shared constants, word map and request/response types of the gpio pin controller
// no dependencies; imported by gpc_regfile and gpio_pin_controller

package gpc_pkg;

    localparam int PIN_COUNT     = 54;
    localparam int PAD_W         = 54;
    localparam int DATA_W        = 32;
    localparam int WORD_W        = 6;
    localparam int FSEL_W        = 3;
    localparam int PINS_PER_WORD = 10;
    localparam int FSEL_WORDS    = 6;
    localparam int BANK_W        = 2 * DATA_W;
    localparam int PULL_W        = 2;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    // register word offsets
    localparam logic [WORD_W-1:0] W_FSEL0   = 6'd0;
    localparam logic [WORD_W-1:0] W_FSEL5   = 6'd5;
    localparam logic [WORD_W-1:0] W_SET0    = 6'd7;
    localparam logic [WORD_W-1:0] W_SET1    = 6'd8;
    localparam logic [WORD_W-1:0] W_CLR0    = 6'd10;
    localparam logic [WORD_W-1:0] W_CLR1    = 6'd11;
    localparam logic [WORD_W-1:0] W_LEV0    = 6'd13;
    localparam logic [WORD_W-1:0] W_LEV1    = 6'd14;
    localparam logic [WORD_W-1:0] W_PUD     = 6'd37;
    localparam logic [WORD_W-1:0] W_PUDCLK0 = 6'd38;
    localparam logic [WORD_W-1:0] W_PUDCLK1 = 6'd39;

    localparam logic [PULL_W-1:0] PULL_OFF  = 2'd0;
    localparam logic [PULL_W-1:0] PULL_DOWN = 2'd1;
    localparam logic [PULL_W-1:0] PULL_UP   = 2'd2;

    localparam logic [FSEL_W-1:0] FSEL_IN  = 3'd0;
    localparam logic [FSEL_W-1:0] FSEL_OUT = 3'd1;

    typedef struct packed {
        t_op               op;
        logic [WORD_W-1:0] word;
        logic [DATA_W-1:0] data;
        logic [PAD_W-1:0]  pads;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic [PAD_W-1:0]  levels;
        logic [PAD_W-1:0]  enables;
        logic [PAD_W-1:0]  pull_up;
        logic [PAD_W-1:0]  pull_down;
    } t_rsp;

endpackage

// ===== src/gpc_regfile.sv =====
// gpc_regfile: pin state registers and the single-pass read/write logic of one bus request
// depends on gpc_pkg; the response reflects the state after the request

module gpc_regfile (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_commit,
    input  gpc_pkg::t_req i_req,
    output gpc_pkg::t_rsp o_rsp
);
    import gpc_pkg::*;

    logic [FSEL_W-1:0]    r_fsel [PIN_COUNT];
    logic [FSEL_W-1:0]    n_fsel [PIN_COUNT];
    logic [PIN_COUNT-1:0] r_latch, n_latch;
    logic [PULL_W-1:0]    r_pull_ctl, n_pull_ctl;
    logic [PIN_COUNT-1:0] r_pull_up, n_pull_up;
    logic [PIN_COUNT-1:0] r_pull_dn, n_pull_dn;

    logic [DATA_W-1:0]    rdata;
    logic [PIN_COUNT-1:0] en_next;

    function automatic logic [PAD_W-1:0] fit_pad(input logic [PIN_COUNT-1:0] v);
        logic [BANK_W-1:0] x;
        x = BANK_W'(v);
        return x[PAD_W-1:0];
    endfunction

    always_comb begin
        logic [BANK_W-1:0]    bank;
        logic [BANK_W-1:0]    pad_w;
        logic [BANK_W-1:0]    lev_w;
        logic [PIN_COUNT-1:0] bits;
        logic [PIN_COUNT-1:0] en_cur;
        logic [PIN_COUNT-1:0] pads;
        logic                 hi;
        int                   p;

        n_fsel     = r_fsel;
        n_latch    = r_latch;
        n_pull_ctl = r_pull_ctl;
        n_pull_up  = r_pull_up;
        n_pull_dn  = r_pull_dn;
        rdata      = '0;
        p          = 0;

        // the upper word of each set, clear and pull-clock pair addresses pins 32 and up
        hi = (i_req.word == W_SET1) || (i_req.word == W_CLR1) || (i_req.word == W_PUDCLK1);
        bank = hi ? {i_req.data, {DATA_W{1'b0}}} : BANK_W'(i_req.data);
        bits = bank[PIN_COUNT-1:0];

        for (int i = 0; i < PIN_COUNT; i++) begin
            en_cur[i] = (r_fsel[i] == FSEL_OUT);
        end
        pad_w = BANK_W'(i_req.pads);
        pads  = pad_w[PIN_COUNT-1:0];
        lev_w = BANK_W'((r_latch & en_cur) | (pads & ~en_cur));

        if (i_req.op == OP_READ) begin
            case (i_req.word) inside
                [W_FSEL0:W_FSEL5]: begin
                    for (int w = 0; w < FSEL_WORDS; w++) begin
                        for (int k = 0; k < PINS_PER_WORD; k++) begin
                            p = w * PINS_PER_WORD + k;
                            if (i_req.word == WORD_W'(w) && p < PIN_COUNT) begin
                                rdata[FSEL_W*k +: FSEL_W] = r_fsel[p];
                            end
                        end
                    end
                end
                W_LEV0:  rdata = lev_w[DATA_W-1:0];
                W_LEV1:  rdata = lev_w[BANK_W-1:DATA_W];
                W_PUD:   rdata = DATA_W'(r_pull_ctl);
                default: rdata = '0;
            endcase
        end else begin
            case (i_req.word) inside
                [W_FSEL0:W_FSEL5]: begin
                    for (int w = 0; w < FSEL_WORDS; w++) begin
                        for (int k = 0; k < PINS_PER_WORD; k++) begin
                            p = w * PINS_PER_WORD + k;
                            if (i_req.word == WORD_W'(w) && p < PIN_COUNT) begin
                                n_fsel[p] = i_req.data[FSEL_W*k +: FSEL_W];
                            end
                        end
                    end
                end
                W_SET0, W_SET1: n_latch = r_latch | bits;
                W_CLR0, W_CLR1: n_latch = r_latch & ~bits;
                W_PUD:          n_pull_ctl = i_req.data[PULL_W-1:0];
                W_PUDCLK0, W_PUDCLK1: begin
                    // clocked pins take the latched control; off and the spare code clear both
                    n_pull_up = (r_pull_up & ~bits) | ((r_pull_ctl == PULL_UP) ? bits : '0);
                    n_pull_dn = (r_pull_dn & ~bits) | ((r_pull_ctl == PULL_DOWN) ? bits : '0);
                end
                default: ;
            endcase
        end

        for (int i = 0; i < PIN_COUNT; i++) begin
            en_next[i] = (n_fsel[i] == FSEL_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIN_COUNT; i++) begin
                r_fsel[i] <= FSEL_IN;
            end
            r_latch    <= '0;
            r_pull_ctl <= PULL_OFF;
            r_pull_up  <= '0;
            r_pull_dn  <= '0;
        end else if (i_commit) begin
            r_fsel     <= n_fsel;
            r_latch    <= n_latch;
            r_pull_ctl <= n_pull_ctl;
            r_pull_up  <= n_pull_up;
            r_pull_dn  <= n_pull_dn;
        end
    end

    assign o_rsp.rdata     = rdata;
    assign o_rsp.levels    = fit_pad(n_latch);
    assign o_rsp.enables   = fit_pad(en_next);
    assign o_rsp.pull_up   = fit_pad(n_pull_up);
    assign o_rsp.pull_down = fit_pad(n_pull_dn);

endmodule

// ===== src/gpio_pin_controller.sv =====
// gpio_pin_controller: top level, request register, result register and handshake
// depends on gpc_pkg and gpc_regfile
//
//  channel   direction  handshake           payload
//  request   in         i_valid / o_stall   i_opcode, i_word_index, i_write_data, i_pad_levels
//  result    out        o_valid / i_stall   o_read_data, o_drive_levels, o_drive_enables,
//                                           o_pull_up_enables, o_pull_down_enables
//
//  one request per cycle sustained while i_stall is low; each result goes from the request
//  register through one pass of the register file logic into the result register
//  synchronous active-low reset clears all pin state and both valid flags
//  a stalled result holds the result register; the request register keeps one more request,
//  and o_stall rises only while both are full and i_stall is high

module gpio_pin_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_opcode,
    input  logic [gpc_pkg::WORD_W-1:0]  i_word_index,
    input  logic [gpc_pkg::DATA_W-1:0]  i_write_data,
    input  logic [gpc_pkg::PAD_W-1:0]   i_pad_levels,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [gpc_pkg::DATA_W-1:0]  o_read_data,
    output logic [gpc_pkg::PAD_W-1:0]   o_drive_levels,
    output logic [gpc_pkg::PAD_W-1:0]   o_drive_enables,
    output logic [gpc_pkg::PAD_W-1:0]   o_pull_up_enables,
    output logic [gpc_pkg::PAD_W-1:0]   o_pull_down_enables
);
    import gpc_pkg::*;

    logic r_in_valid, n_in_valid;
    t_req r_req;
    logic r_out_valid, n_out_valid;
    t_rsp r_rsp;
    t_rsp rsp;
    logic in_take;
    logic advance;

    assign advance = r_in_valid && !(r_out_valid && i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign in_take = i_valid && !o_stall;

    gpc_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (advance),
        .i_req    (r_req),
        .o_rsp    (rsp)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req <= '{op: t_op'(i_opcode), word: i_word_index,
                       data: i_write_data, pads: i_pad_levels};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rsp       <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_rsp <= rsp;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_read_data         = r_rsp.rdata;
    assign o_drive_levels      = r_rsp.levels;
    assign o_drive_enables     = r_rsp.enables;
    assign o_pull_up_enables   = r_rsp.pull_up;
    assign o_pull_down_enables = r_rsp.pull_down;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && o_valid && i_stall))
        else $error("upstream stalled while the pipeline has room");

    a_write_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_req.op == OP_WRITE) |=> (o_read_data == '0))
        else $error("write request returned nonzero read data");

    a_pulls_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pull_up_enables & o_pull_down_enables) == '0)
        else $error("pin has both pull-up and pull-down enabled");

    a_latch_only_by_set_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !(r_req.op == OP_WRITE && (r_req.word == W_SET0 || r_req.word == W_SET1
            || r_req.word == W_CLR0 || r_req.word == W_CLR1)))
        |=> (o_drive_levels == $past(o_drive_levels)))
        else $error("output latch changed without a set or clear write");

endmodule
